// ===== rtl/core/lia_pkg.sv =====
`timescale 1ns / 1ps

package lia_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int LAST_W      = 10;
  localparam int SAMPLE_W    = 32;
  localparam int ENTRY_W     = 32;
  localparam int ACT_W       = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_ARGUMENT_SCALE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_TABLE_INDEX = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION_SELECT  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MULTIPLY_ENABLE  = 2'd3;

  localparam logic [31:0]       RESET_ARGUMENT_SCALE   = 32'd65536;
  localparam logic [LAST_W-1:0] RESET_LAST_TABLE_INDEX = 10'd1023;

  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

  localparam logic FUNC_TANH     = 1'b0;
  localparam logic FUNC_LOGISTIC = 1'b1;

  typedef struct packed {
    logic [31:0]       argument_scale;
    logic [LAST_W-1:0] last_table_index;
    logic              function_select;
    logic              multiply_enable;
  } cfg_t;

  typedef struct packed {
    logic                       beyond;
    logic                       neg;
    logic [30:0]                frac;
    logic signed [SAMPLE_W-1:0] multiplier;
    logic                       block_end;
  } meta_t;

endpackage

// ===== rtl/core/lia_cfg.sv =====
`timescale 1ns / 1ps

module lia_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lia_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lia_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lia_pkg::cfg_t                   cfg
);
  import lia_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.argument_scale   <= RESET_ARGUMENT_SCALE;
      cfg.last_table_index <= RESET_LAST_TABLE_INDEX;
      cfg.function_select  <= FUNC_TANH;
      cfg.multiply_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ARGUMENT_SCALE:   cfg.argument_scale   <= cfg_data;
        CFG_LAST_TABLE_INDEX: cfg.last_table_index <= cfg_data[LAST_W-1:0];
        CFG_FUNCTION_SELECT:  cfg.function_select  <= cfg_data[0];
        CFG_MULTIPLY_ENABLE:  cfg.multiply_enable  <= cfg_data[0];
      endcase
    end
  end

endmodule

// ===== rtl/core/lia_table.sv =====
`timescale 1ns / 1ps

module lia_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lia_pkg::ENTRY_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr0,
  input  logic [AW-1:0]               raddr1,
  output logic [lia_pkg::ENTRY_W-1:0] rdata0,
  output logic [lia_pkg::ENTRY_W-1:0] rdata1
);
  import lia_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== rtl/core/lia_interp.sv =====
`timescale 1ns / 1ps

module lia_interp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lia_pkg::meta_t              meta_in,
  input  logic [lia_pkg::ENTRY_W-1:0] rdata0,
  input  logic [lia_pkg::ENTRY_W-1:0] rdata1,
  input  lia_pkg::cfg_t               cfg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lia_pkg::ACT_W-1:0]   activation,
  output logic                        beyond_table,
  output logic                        block_end_out
);
  import lia_pkg::*;

  localparam logic signed [33:0] ONE_V   = 34'sd1073741824;
  localparam logic signed [34:0] ONE_R   = 35'sd1073741824;
  localparam logic [ACT_W-1:0]   ACT_MAX = {1'b0, {(ACT_W-1){1'b1}}};
  localparam logic [ACT_W-1:0]   ACT_MIN = {1'b1, {(ACT_W-1){1'b0}}};

  logic va, vb, vc, vd, ve;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_o;

  meta_t a_meta, b_meta, c_meta, d_meta, e_meta;

  logic signed [32:0] b_diff;
  logic [31:0]        b_l0, c_l0;
  logic signed [64:0] c_prod;
  logic signed [33:0] v_interp, v_sel;
  logic signed [34:0] v_ext, r_next, d_r, e_r;
  logic signed [50:0] e_phi;
  logic signed [51:0] e_plo;
  logic signed [51:0] mul_sum, chosen;
  logic [ACT_W-1:0]   act_next;

  assign rdy_o    = !out_valid || !out_stall;
  assign rdy_e    = !ve || rdy_o;
  assign rdy_d    = !vd || rdy_e;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  // interpolation and symmetry
  always_comb begin
    v_interp = $signed({{2{c_l0[31]}}, c_l0}) + c_prod[64:31];
    v_sel    = c_meta.beyond ? ONE_V : v_interp;
    v_ext    = {v_sel[33], v_sel};
    r_next   = v_ext;
    if (c_meta.neg) begin
      r_next = (cfg.function_select == FUNC_LOGISTIC) ? ONE_R - v_ext : -v_ext;
    end
  end

  // multiplier recombination and saturation
  always_comb begin
    mul_sum = {e_phi[50], e_phi} + {{16{e_plo[51]}}, e_plo[51:16]};
    chosen  = cfg.multiply_enable ? mul_sum : {{17{e_r[34]}}, e_r};
    if (chosen[51:47] == {5{chosen[51]}}) begin
      act_next = chosen[ACT_W-1:0];
    end else if (chosen[51]) begin
      act_next = ACT_MIN;
    end else begin
      act_next = ACT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      ve        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
      if (rdy_e) ve <= vd;
      if (rdy_o) out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_meta <= meta_in;
    end
    if (rdy_b && va) begin
      b_diff <= $signed({rdata1[31], rdata1}) - $signed({rdata0[31], rdata0});
      b_l0   <= rdata0;
      b_meta <= a_meta;
    end
    if (rdy_c && vb) begin
      c_prod <= 65'(b_diff) * 65'($signed({1'b0, b_meta.frac}));
      c_l0   <= b_l0;
      c_meta <= b_meta;
    end
    if (rdy_d && vc) begin
      d_r    <= r_next;
      d_meta <= c_meta;
    end
    if (rdy_e && vd) begin
      e_phi  <= 51'(d_r) * 51'($signed(d_meta.multiplier[31:16]));
      e_plo  <= 52'(d_r) * 52'($signed({1'b0, d_meta.multiplier[15:0]}));
      e_r    <= d_r;
      e_meta <= d_meta;
    end
    if (rdy_o && ve) begin
      activation    <= act_next;
      beyond_table  <= e_meta.beyond;
      block_end_out <= e_meta.block_end;
    end
  end

endmodule

// ===== rtl/core/lut_interpolated_activation.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            word
// in        input      in_valid / in_stall  operation, sample, multiplier, entry_index,
//                                           entry_value, block_end
// out       output     out_valid/out_stall  activation, beyond_table, block_end_out
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word accepted per cycle while in_stall is low; an evaluate word passes the input
// register, the table read (two read ports, one write port) and the split multipliers
// write words update the table and give no result
// rst is synchronous and clears the valid chain and resets the config registers; table is not cleared
// out_stall holds each stage only while the next one is full, bubbles still close up

module lut_interpolated_activation #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  operation,
  input  logic signed [lia_pkg::SAMPLE_W-1:0]   sample,
  input  logic signed [lia_pkg::SAMPLE_W-1:0]   multiplier,
  input  logic [lia_pkg::LAST_W-1:0]            entry_index,
  input  logic signed [lia_pkg::ENTRY_W-1:0]    entry_value,
  input  logic                                  block_end,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lia_pkg::ACT_W-1:0]      activation,
  output logic                                  beyond_table,
  output logic                                  block_end_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lia_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [lia_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import lia_pkg::*;

  localparam int          AW      = $clog2(TABLE_DEPTH);
  localparam logic [31:0] MAX_IDX = 32'(TABLE_DEPTH - 1);
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  cfg_t cfg;

  logic               valid1;
  logic               op1;
  logic [63:0]        pos1;
  logic               neg1;
  logic [31:0]        mult1;
  logic [LAST_W-1:0]  idx1;
  logic [ENTRY_W-1:0] val1;
  logic               bend1;

  logic [31:0]  mag;
  logic [31:0]  ipart, last_ext, last_eff, idx_ext;
  logic         beyond;
  logic         ready1, leave1, a_ready;
  logic         we, re;
  logic [AW-1:0] raddr0, raddr1;
  logic [ENTRY_W-1:0] rdata0, rdata1;
  logic [ACT_W-1:0]   act_raw;
  meta_t meta;

  lia_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign mag = sample[31] ? (~sample + 32'd1) : sample;

  assign leave1   = valid1 && ((op1 == OP_WRITE) || a_ready);
  assign ready1   = !valid1 || leave1;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ready1) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      op1   <= operation;
      pos1  <= {32'd0, mag} * {32'd0, cfg.argument_scale};
      neg1  <= sample[31];
      mult1 <= multiplier;
      idx1  <= entry_index;
      val1  <= entry_value;
      bend1 <= block_end;
    end
  end

  always_comb begin
    ipart    = pos1[63:32];
    last_ext = {{(32-LAST_W){1'b0}}, cfg.last_table_index};
    last_eff = (last_ext > MAX_IDX) ? MAX_IDX : last_ext;
    beyond   = ipart >= last_eff;
    raddr0   = beyond ? '0 : ipart[AW-1:0];
    raddr1   = raddr0 + AW'(1);
    idx_ext  = {{(32-LAST_W){1'b0}}, idx1};
    we       = leave1 && (op1 == OP_WRITE) && (idx_ext < DEPTH32);
    re       = leave1 && (op1 == OP_EVALUATE);
    meta.beyond     = beyond;
    meta.neg        = neg1;
    meta.frac       = pos1[31:1];
    meta.multiplier = mult1;
    meta.block_end  = bend1;
  end

  lia_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .we     (we),
    .waddr  (idx_ext[AW-1:0]),
    .wdata  (val1),
    .re     (re),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  lia_interp u_interp (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (valid1 && (op1 == OP_EVALUATE)),
    .in_ready      (a_ready),
    .meta_in       (meta),
    .rdata0        (rdata0),
    .rdata1        (rdata1),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .activation    (act_raw),
    .beyond_table  (beyond_table),
    .block_end_out (block_end_out)
  );

  assign activation = act_raw;

endmodule

// ===== sim/lut_interpolated_activation_tb.sv =====
`timescale 1ns / 1ps

module lut_interpolated_activation_tb;
  import lia_pkg::*;

  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam longint OUT_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam longint OUT_MIN = -(64'sd1 <<< 47);

  typedef struct packed {
    logic               op;
    logic signed [31:0] sample;
    logic signed [31:0] multiplier;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_value;
    logic               block_end;
  } act_word_t;

  typedef struct packed {
    logic signed [ACT_W-1:0] activation;
    logic                    beyond;
    logic                    block_end;
  } act_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       operation = OP_EVALUATE;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic signed [SAMPLE_W-1:0] multiplier = '0;
  logic [LAST_W-1:0]          entry_index = '0;
  logic signed [ENTRY_W-1:0]  entry_value = '0;
  logic                       block_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [ACT_W-1:0]    activation;
  logic                       beyond_table;
  logic                       block_end_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  lut_interpolated_activation uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .sample(sample), .multiplier(multiplier),
    .entry_index(entry_index), .entry_value(entry_value), .block_end(block_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .activation(activation), .beyond_table(beyond_table), .block_end_out(block_end_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  act_word_t          pending_words[$];
  act_result_t        expected_results[$];
  logic signed [31:0] entry_copy [0:1023];
  bit                 loaded [0:1023];
  cfg_t               model_cfg;
  int                 errors = 0;
  int                 idle_pct = 0;
  bit                 quiet = 1'b0;
  int                 send_gap = 0;
  int                 take_gap = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] position_of(logic signed [31:0] s);
    logic [31:0] mag;
    mag = s[31] ? (~s + 32'd1) : s;
    return {32'd0, mag} * {32'd0, model_cfg.argument_scale};
  endfunction

  function automatic act_result_t activation_of(act_word_t w);
    logic [63:0] pos;
    logic [31:0] ip;
    longint      l0, l1, frac, v, r;
    act_result_t res;
    pos = position_of(w.sample);
    ip = pos[63:32];
    res.beyond = (ip >= model_cfg.last_table_index);
    if (res.beyond) begin
      v = ONE_Q30;
    end else begin
      l0 = entry_copy[ip[9:0]];
      l1 = entry_copy[ip[9:0] + 10'd1];
      frac = {33'd0, pos[31:1]};
      v = l0 + (((l1 - l0) * frac) >>> 31);
    end
    if (model_cfg.function_select == FUNC_LOGISTIC) begin
      r = w.sample[31] ? ONE_Q30 - v : v;
    end else begin
      r = w.sample[31] ? -v : v;
    end
    if (model_cfg.multiply_enable) begin
      r = (r * longint'(w.multiplier)) >>> 16;
    end
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < OUT_MIN) begin
      r = OUT_MIN;
    end
    res.activation = r[47:0];
    res.block_end = w.block_end;
    return res;
  endfunction

  // word taken by the block
  task automatic absorb_word(input act_word_t w);
    if (w.op == OP_WRITE) begin
      entry_copy[w.entry_index] = w.entry_value;
    end else begin
      expected_results.push_back(activation_of(w));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_word('{operation, sample, multiplier, entry_index, entry_value, block_end});
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 11) - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          act_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          operation <= w.op;
          sample <= w.sample;
          multiplier <= w.multiplier;
          entry_index <= w.entry_index;
          entry_value <= w.entry_value;
          block_end <= w.block_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected word, activation", activation, 0);
        end else begin
          act_result_t e;
          e = expected_results.pop_front();
          if (activation !== e.activation) begin
            note_mismatch("activation", activation, e.activation);
          end
          if (beyond_table !== e.beyond) begin
            note_mismatch("beyond_table", beyond_table, e.beyond);
          end
          if (block_end_out !== e.block_end) begin
            note_mismatch("block_end_out", block_end_out, e.block_end);
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        take_gap = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ARGUMENT_SCALE:   model_cfg.argument_scale = data;
      CFG_LAST_TABLE_INDEX: model_cfg.last_table_index = data[LAST_W-1:0];
      CFG_FUNCTION_SELECT:  model_cfg.function_select = data[0];
      CFG_MULTIPLY_ENABLE:  model_cfg.multiply_enable = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] scale, input logic [9:0] last,
                            input logic func, input logic mult);
    write_reg(CFG_ARGUMENT_SCALE, scale);
    write_reg(CFG_LAST_TABLE_INDEX, {22'd0, last});
    write_reg(CFG_FUNCTION_SELECT, {31'd0, func});
    write_reg(CFG_MULTIPLY_ENABLE, {31'd0, mult});
  endtask

  // wait until every word is taken and every result is back, then let the pipe settle
  task automatic drain_all();
    int waited;
    waited = 0;
    while ((pending_words.size() != 0 || in_valid || expected_results.size() != 0)
           && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      note_mismatch("results never arrived, count", expected_results.size(), 0);
      expected_results.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic queue_write(input logic [9:0] idx, input logic [31:0] val);
    loaded[idx] = 1'b1;
    pending_words.push_back('{OP_WRITE, $urandom(), $urandom(), idx, val,
                              1'($urandom_range(0, 1))});
  endtask

  task automatic queue_evaluate(input logic [31:0] s, input logic [31:0] m, input logic be);
    pending_words.push_back('{OP_EVALUATE, s, m, 10'($urandom_range(0, 1023)), $urandom(), be});
  endtask

  // only positions whose two neighbours were loaded, or beyond the last index
  function automatic bit readable(logic signed [31:0] s);
    logic [63:0] pos;
    pos = position_of(s);
    return pos[63:32] >= model_cfg.last_table_index ||
           (loaded[pos[41:32]] && loaded[pos[41:32] + 10'd1]);
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [63:0]        mag;
    logic signed [31:0] s;
    int unsigned        i, top;
    for (int tries = 0; tries < 40; tries++) begin
      if ($urandom_range(0, 99) < 65 && model_cfg.last_table_index > 0) begin
        top = model_cfg.last_table_index - 1;
        if ($urandom_range(0, 1) && top > 63) begin
          top = 63;
        end
        i = $urandom_range(0, top);
        if (model_cfg.argument_scale == 0) begin
          mag = {32'd0, $urandom()};
        end else begin
          mag = {i, $urandom()} / {32'd0, model_cfg.argument_scale};
        end
        if (mag > 64'h8000_0000) begin
          continue;
        end
        s = mag[31:0];
      end else if ($urandom_range(0, 1)) begin
        s = $urandom();
      end else begin
        s = $urandom_range(0, 1 << 22);
      end
      if ($urandom_range(0, 1)) begin
        s = -s;
      end
      if (readable(s)) begin
        return s;
      end
    end
    return 32'd0;
  endfunction

  function automatic logic [31:0] pick_multiplier();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4, 5, 6, 7, 8, 9: return $urandom();
      default: return $urandom_range(0, 1 << 30);
    endcase
  endfunction

  // runs of consecutive entry loads mixed with evaluate words
  task automatic random_burst(input int n);
    int made, run, start;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 15) begin
        run = $urandom_range(1, 8);
        start = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 1024 - run);
        for (int k = 0; k < run; k++) begin
          queue_write(10'(start + k), pick_entry());
        end
        made += run;
      end else begin
        queue_evaluate(pick_sample(), pick_multiplier(), $urandom_range(0, 7) == 0);
        made++;
      end
    end
  endtask

  initial begin
    logic [31:0] scale;
    logic [9:0]  last;
    logic        func, mult;
    model_cfg.argument_scale = RESET_ARGUMENT_SCALE;
    model_cfg.last_table_index = RESET_LAST_TABLE_INDEX;
    model_cfg.function_select = FUNC_TANH;
    model_cfg.multiply_enable = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: tanh, unit scale, full table
    queue_write(10'd0, 32'h0000_0000);
    queue_write(10'd1, 32'h7FFF_FFFF);
    queue_write(10'd2, 32'h8000_0000);
    queue_write(10'd3, 32'h3000_0000);
    queue_write(10'd512, 32'h1234_5678);
    queue_write(10'd1022, 32'h3FFF_FFF0);
    queue_write(10'd1023, 32'h4000_0000);
    queue_evaluate(32'h0000_0000, $urandom(), 1'b0);
    queue_evaluate(32'h0000_8000, $urandom(), 1'b0);
    queue_evaluate(-32'sh0001_8000, $urandom(), 1'b1);
    queue_evaluate(32'h0002_FFFF, $urandom(), 1'b0);
    queue_evaluate(32'h03FE_C000, $urandom(), 1'b0);
    queue_evaluate(-32'sh03FF_0000, $urandom(), 1'b0);
    queue_evaluate(32'h7FFF_FFFF, $urandom(), 1'b0);
    queue_evaluate(32'h8000_0000, $urandom(), 1'b1);
    drain_all();

    // logistic with multiplier extremes
    set_config(32'd65536, 10'd1023, FUNC_LOGISTIC, 1'b1);
    queue_evaluate(32'h0000_8000, 32'h7FFF_FFFF, 1'b0);
    queue_evaluate(-32'sh0001_8000, 32'h8000_0000, 1'b0);
    queue_evaluate(-32'sh0002_0000, 32'h8000_0000, 1'b0);
    queue_evaluate(32'h0002_FFFF, 32'h0001_0000, 1'b0);
    queue_evaluate(32'h8000_0000, 32'h0000_0000, 1'b1);
    drain_all();

    for (int ph = 0; ph < 8; ph++) begin
      scale = $urandom_range(0, 1) ? $urandom_range(1 << 14, 1 << 20) : $urandom();
      last = 10'($urandom_range(1, 1023));
      func = 1'($urandom_range(0, 1));
      mult = 1'($urandom_range(0, 1));
      case (ph)
        0: set_config(32'd65536, 10'd1023, FUNC_TANH, 1'b0);
        1: set_config(32'd0, last, FUNC_LOGISTIC, 1'b0);
        2: set_config(32'hFFFF_FFFF, 10'd1023, FUNC_TANH, 1'b1);
        3: set_config($urandom_range(1 << 15, 1 << 18), 10'd1, FUNC_LOGISTIC, 1'b1);
        4: set_config(scale, 10'd0, FUNC_TANH, 1'b1);
        default: set_config(scale, last, func, mult);
      endcase
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 8;
        default: idle_pct = 25;
      endcase
      quiet = (ph == 7);
      random_burst(68);
      drain_all();
      random_burst(68);
      drain_all();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lia_pkg.sv
rtl/core/lia_cfg.sv
rtl/core/lia_table.sv
rtl/core/lia_interp.sv
rtl/core/lut_interpolated_activation.sv
sim/lut_interpolated_activation_tb.sv
